FILE: rtl/core/wfba_pkg.sv
// shared types and constants of the worst-fit block allocator
`default_nettype none
package wfba_pkg;

	localparam int FREE_W  = 20;
	localparam int SLOT_W  = 4;
	localparam int AMT_W   = 16;
	localparam int CHOSE_W = 4;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// per-cell control: ring rotation and a direct write
	typedef struct packed {
		logic shift;
		logic wr;
		logic wr_used;
	} wfba_cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} wfba_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/wfba_cell.sv
// one block entry of the rotating ring: remaining size and used mark
`default_nettype none
module wfba_cell #(
	parameter int SIZE_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire wfba_pkg::wfba_cell_ctrl_t ctrl,
	input  wire logic [SIZE_BITS-1:0]      wr_size,
	input  wire logic [SIZE_BITS-1:0]      nxt_size,
	input  wire logic                      nxt_used,
	output logic      [SIZE_BITS-1:0]      size,
	output logic                           used
);
	import wfba_pkg::*;

	logic [SIZE_BITS-1:0] size_q;
	logic                 used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			used_q <= 1'b0;
		end else if (ctrl.wr) begin
			size_q <= wr_size;
			used_q <= ctrl.wr_used;
		end else if (ctrl.shift) begin
			size_q <= nxt_size;
			used_q <= nxt_used;
		end
	end

	assign size = size_q;
	assign used = used_q;

endmodule
`default_nettype wire

FILE: rtl/core/worst_fit_block_allocator_unit.sv
// worst-fit block allocator top level: ring of block cells, scan head and control
// a request is accepted, the block ring turns once past the scan head (one block per cycle),
//   then the finish state registers the result once the output register is free or being emptied
// one request at a time: in_stall is held until the previous request has finished
// reset: arst_n clears all block sizes and used marks, the control state and the
//   output valid; no clearing pass is needed
`default_nettype none
module worst_fit_block_allocator_unit #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire logic [wfba_pkg::SLOT_W-1:0]   slot,
	input  wire logic [wfba_pkg::AMT_W-1:0]    amount,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               granted,
	output logic      [wfba_pkg::CHOSE_W-1:0]  chosen_block,
	output logic      [wfba_pkg::FREE_W-1:0]   untouched_free,
	output logic                               fragmented
);
	import wfba_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	// wide enough for the sum of all blocks without overflow
	localparam int SUM_W = SIZE_BITS + IDX_W + 1;
	// common compare width for totals against the saturation limit
	localparam int CMP_W = (SUM_W > FREE_W) ? SUM_W + 1 : FREE_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	wfba_state_t state_q;

	// latched request
	logic             op_q;
	logic [AMT_W-1:0] amount_q;

	// scan head accumulators
	logic [IDX_W-1:0]     cnt_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic                 best_used_q;
	logic [SUM_W-1:0]     sum_q;

	// ring of cells
	logic [SIZE_BITS-1:0] cell_size [NUM_BLOCKS];
	logic                 cell_used [NUM_BLOCKS];
	wfba_cell_ctrl_t      cell_ctrl [NUM_BLOCKS];
	logic [SIZE_BITS-1:0] wr_size;

	logic accept;
	logic fin_go;
	logic fit;
	logic [SIZE_BITS-1:0] load_size;
	logic [SIZE_BITS-1:0] new_size;
	logic [SUM_W-1:0]     total_raw;
	logic [CMP_W-1:0]     total_ext;
	logic [FREE_W-1:0]    total_sat;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// finish only when the output register is free or being emptied
	assign fin_go   = (state_q == ST_FIN) && !(out_valid && out_stall);

	// load amount fitted to a block's width
	assign load_size = SIZE_BITS'(32'(amount));

	// result arithmetic on the scan outcome
	assign fit      = (32'(amount_q) <= 32'(best_size_q));
	assign new_size = SIZE_BITS'(32'(best_size_q) - 32'(amount_q));

	always_comb begin
		// a granted request marks the best block used, so its size leaves the total
		if (op_q == OP_ALLOC && fit && !best_used_q) begin
			total_raw = sum_q - SUM_W'(best_size_q);
		end else begin
			total_raw = sum_q;
		end
		total_ext = CMP_W'(total_raw);
		if (total_ext > CMP_W'({FREE_W{1'b1}})) begin
			total_sat = {FREE_W{1'b1}};
		end else begin
			total_sat = FREE_W'(total_ext);
		end
	end

	// write data: a load at acceptance, a granted update at finish
	assign wr_size = accept ? load_size : new_size;

	generate
		for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
			localparam int NXT = (i + 1) % NUM_BLOCKS;

			always_comb begin
				cell_ctrl[i].shift   = (state_q == ST_SCAN);
				cell_ctrl[i].wr      =
					(accept && op == OP_LOAD && 32'(slot) == 32'(i)) ||
					(fin_go && op_q == OP_ALLOC && fit && 32'(best_idx_q) == 32'(i));
				cell_ctrl[i].wr_used = !accept;
			end

			wfba_cell #(
				.SIZE_BITS (SIZE_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl[i]),
				.wr_size  (wr_size),
				.nxt_size (cell_size[NXT]),
				.nxt_used (cell_used[NXT]),
				.size     (cell_size[i]),
				.used     (cell_used[i])
			);
		end
	endgenerate

	// control: idle, one ring turn, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					// ring is back home after the last block passes the head
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			amount_q <= amount;
		end
	end

	// scan head: cell 0 shows block cnt_q during the turn
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			// strict compare keeps the lowest index on ties
			if (cnt_q == '0 || cell_size[0] > best_size_q) begin
				best_size_q <= cell_size[0];
				best_idx_q  <= cnt_q;
				best_used_q <= cell_used[0];
			end
			if (cnt_q == '0) begin
				sum_q <= cell_used[0] ? '0 : SUM_W'(cell_size[0]);
			end else if (!cell_used[0]) begin
				sum_q <= sum_q + SUM_W'(cell_size[0]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fin_go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			untouched_free <= total_sat;
			if (op_q == OP_ALLOC) begin
				granted      <= fit;
				chosen_block <= fit ? CHOSE_W'(32'(best_idx_q)) : '0;
				fragmented   <= !fit && (CMP_W'(amount_q) <= CMP_W'(total_sat));
			end else begin
				granted      <= 1'b0;
				chosen_block <= '0;
				fragmented   <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/worst_fit_block_allocator_unit_tb.sv
// self-checking testbench of the worst-fit block allocator top level
`default_nettype none
module testbench;

	import wfba_pkg::*;

	localparam int BLOCKS      = 16;
	localparam int SIZE_W      = 16;
	localparam int FREE_CAP    = 20'hFFFFF;
	localparam int DIRECTED_N  = 15;
	localparam int RANDOM_N    = 1000;
	// the drain wait spans two full requests when the receiver does not stall
	localparam int DRAIN_WAIT  = 2 * (BLOCKS + 2);
	// longest quiet stretch of a correct run: sender gap + block turn + receiver stall
	localparam int IDLE_LIMIT  = 2000;
	localparam int REPORT_MAX  = 10;

	// one result of the allocator as seen on the result channel
	typedef struct packed {
		logic                 granted;
		logic [CHOSE_W-1:0]   chosen_block;
		logic [FREE_W-1:0]    untouched_free;
		logic                 fragmented;
	} alloc_result_t;

	// receiver behavior, switched at random during the run
	typedef enum {
		RX_FREE,
		RX_CHOPPY,
		RX_HEAVY
	} rx_mode_t;

	// keeps its own copy of the block table and the results still owed
	class alloc_scoreboard;
		bit [SIZE_W-1:0] block_size [BLOCKS];
		bit              block_used [BLOCKS];
		alloc_result_t   pending_results [$];
		int              failures;

		function new();
			for (int k = 0; k < BLOCKS; k++) begin
				block_size[k] = '0;
				block_used[k] = 1'b0;
			end
			failures = 0;
		endfunction

		// saturated sum of sizes in blocks not marked used
		function int free_total();
			int sum;
			sum = 0;
			for (int k = 0; k < BLOCKS; k++)
				if (!block_used[k])
					sum += block_size[k];
			return (sum > FREE_CAP) ? FREE_CAP : sum;
		endfunction

		// worst-fit pick: largest size, lowest index on ties
		function int largest_index();
			int best;
			best = 0;
			for (int k = 1; k < BLOCKS; k++)
				if (block_size[k] > block_size[best])
					best = k;
			return best;
		endfunction

		function int largest_size();
			return block_size[largest_index()];
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// apply one accepted request to the table and queue what it must produce
		function void note_request(logic req_op, logic [SLOT_W-1:0] req_slot,
				logic [AMT_W-1:0] req_amount);
			alloc_result_t r;
			int            best;
			r = '0;
			if (req_op == OP_LOAD) begin
				if (int'(req_slot) < BLOCKS) begin
					block_size[req_slot] = req_amount[SIZE_W-1:0];
					block_used[req_slot] = 1'b0;
				end
				r.untouched_free = FREE_W'(free_total());
			end else begin
				best = largest_index();
				if (req_amount <= block_size[best]) begin
					block_size[best] = block_size[best] - req_amount;
					block_used[best] = 1'b1;
					r.granted = 1'b1;
					r.chosen_block = best[CHOSE_W-1:0];
					r.untouched_free = FREE_W'(free_total());
				end else begin
					r.untouched_free = FREE_W'(free_total());
					r.fragmented = (int'(req_amount) <= free_total());
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected result: granted=%0d block=%0d free=%0d frag=%0d",
						got.granted, got.chosen_block, got.untouched_free,
						got.fragmented);
				return;
			end
			want = pending_results.pop_front();
			if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
					got.untouched_free !== want.untouched_free ||
					got.fragmented !== want.fragmented) begin
				failures++;
				if (failures <= REPORT_MAX) begin
					$display("mismatch: expected granted=%0d block=%0d free=%0d frag=%0d",
						want.granted, want.chosen_block, want.untouched_free,
						want.fragmented);
					$display("          got      granted=%0d block=%0d free=%0d frag=%0d",
						got.granted, got.chosen_block, got.untouched_free,
						got.fragmented);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                op;
	logic [SLOT_W-1:0]   slot;
	logic [AMT_W-1:0]    amount;
	logic                out_valid;
	logic                out_stall;
	logic                granted;
	logic [CHOSE_W-1:0]  chosen_block;
	logic [FREE_W-1:0]   untouched_free;
	logic                fragmented;

	alloc_scoreboard sb;
	int              idle_cycles = 0;
	int              burst_left;
	int              requests_sent;

	worst_fit_block_allocator_unit #(
		.NUM_BLOCKS(BLOCKS),
		.SIZE_BITS (SIZE_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.slot          (slot),
		.amount        (amount),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.granted       (granted),
		.chosen_block  (chosen_block),
		.untouched_free(untouched_free),
		.fragmented    (fragmented)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// monitor: both handshakes are sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid === 1'b1 && in_stall === 1'b0)
				sb.note_request(op, slot, amount);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				sb.check_result({granted, chosen_block, untouched_free, fragmented});
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog: too long without any request or result moving
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
		$display("worst_fit_block_allocator_unit test failed");
		$finish;
	end

	// receiver: its own stall pattern, changed after each run of random length
	initial begin
		rx_mode_t mode;
		int       run;
		int       hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 2));
			run = $urandom_range(40, 300);
			while (run > 0) begin
				case (mode)
					RX_FREE: begin
						hold = 1;
						@(negedge clk) out_stall <= 1'b0;
					end
					RX_CHOPPY: begin
						hold = 1;
						@(negedge clk) out_stall <= 1'($urandom_range(0, 1));
					end
					default: begin
						// long stalls with short windows in between
						hold = $urandom_range(1, 25);
						repeat (hold) @(negedge clk) out_stall <= 1'b1;
						@(negedge clk) out_stall <= 1'b0;
						hold++;
					end
				endcase
				run -= hold;
			end
		end
	end

	// sender: puts one request on the channel at a falling edge and waits for it to go in
	task automatic drive_request(logic req_op, logic [SLOT_W-1:0] req_slot,
			logic [AMT_W-1:0] req_amount);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
			// a few long bursts give stretches with no gaps at all
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		op <= req_op;
		slot <= req_slot;
		amount <= req_amount;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
		burst_left--;
		requests_sent++;
	endtask

	// block sizes: empty, full, small and anything
	function automatic logic [AMT_W-1:0] pick_block_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return AMT_W'($urandom_range(1, 255));
			3: return AMT_W'($urandom_range(0, 4095));
			default: return AMT_W'($urandom);
		endcase
	endfunction

	// request sizes aimed at the current largest block and free total
	function automatic logic [AMT_W-1:0] pick_request_size(int largest, int free_sum);
		int top;
		top = (1 << AMT_W) - 1;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return AMT_W'(largest);
			2: return AMT_W'((largest < top) ? largest + 1 : largest);
			// refused, yet fits the untouched total
			3: return AMT_W'((free_sum > largest && largest < top) ?
				$urandom_range(largest + 1, (free_sum < top) ? free_sum : top) : largest);
			4: return AMT_W'($urandom);
			5: return AMT_W'((free_sum < top) ? free_sum + 1 : top);
			default: return AMT_W'($urandom_range(0, largest));
		endcase
	endfunction

	initial begin
		int n;
		sb = new();
		burst_left = 0;
		requests_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_LOAD;
		slot = '0;
		amount = '0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(negedge clk);

		// zero request on an empty table, then one that cannot fit anywhere
		drive_request(OP_ALLOC, 4'd0, 16'h0000);
		drive_request(OP_ALLOC, 4'd5, 16'h0001);
		// two full blocks tie; the lower index wins
		drive_request(OP_LOAD, 4'd15, 16'hFFFF);
		drive_request(OP_LOAD, 4'd7, 16'hFFFF);
		drive_request(OP_ALLOC, 4'd0, 16'hFFFF);
		drive_request(OP_ALLOC, 4'd0, 16'hFFFF);
		// refused but fits the untouched total, then refused outright
		drive_request(OP_LOAD, 4'd3, 16'h0100);
		drive_request(OP_LOAD, 4'd4, 16'h0100);
		drive_request(OP_ALLOC, 4'd0, 16'h0101);
		drive_request(OP_ALLOC, 4'd0, 16'h0201);
		drive_request(OP_ALLOC, 4'd0, 16'h0100);
		// reload clears the used mark, zero-size load
		drive_request(OP_LOAD, 4'd3, 16'h0050);
		drive_request(OP_LOAD, 4'd9, 16'h0000);
		// zero request marks the largest block used
		drive_request(OP_ALLOC, 4'd12, 16'h0000);
		drive_request(OP_LOAD, 4'd0, 16'hFFFF);

		// random part: mostly fill-then-allocate runs, some plain noise
		while (requests_sent < DIRECTED_N + RANDOM_N) begin
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 10);
				repeat (n)
					drive_request(1'($urandom_range(0, 1)),
						SLOT_W'($urandom_range(0, BLOCKS - 1)), AMT_W'($urandom));
			end else begin
				n = $urandom_range(1, BLOCKS);
				repeat (n)
					drive_request(OP_LOAD, SLOT_W'($urandom_range(0, BLOCKS - 1)),
						pick_block_size());
				n = $urandom_range(1, 12);
				repeat (n)
					drive_request(OP_ALLOC, SLOT_W'($urandom_range(0, BLOCKS - 1)),
						pick_request_size(sb.largest_size(), sb.free_total()));
			end
		end
		in_valid <= 1'b0;

		// drain: every result in, then a little longer to catch extra ones
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.failures == 0 && sb.outstanding() == 0) begin
			$display("worst_fit_block_allocator_unit test passed");
		end else begin
			$display("worst_fit_block_allocator_unit test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
